/* rtl/mdf_pkg.sv */
// ----------------------------------------------------------------------------
// mdf_pkg
// Shared types and constants for the message duplicate filter: FNV-1a
// constants, header byte selection codes and the controller/datapath buses.
// ----------------------------------------------------------------------------
package mdf_pkg;

	// FNV-1a 32-bit offset basis and prime
	localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
	localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

	// sender (4) + timestamp (8) + type (1) + length (1)
	localparam logic [3:0] HDR_BYTES = 4'd14;

	// byte select code for the payload byte of the current item
	localparam logic [3:0] SEL_PAYLOAD = 4'd14;

	// cache entry: sender, timestamp, type, hash
	localparam int ENTRY_W = 32 + 64 + 8 + 32;

	typedef logic [3:0] sel_t;

	// commands from controller to datapath
	typedef struct packed {
		logic capture_item; // take item fields at the input transfer
		logic capture_hdr;  // take header fields and restart the hash
		logic mix_en;       // fold the selected byte into the hash
		sel_t byte_sel;     // header byte index or SEL_PAYLOAD
		logic scan_clr;     // restart the cache scan
		logic scan_en;      // run the cache scan
		logic commit;       // load the result and update the cache
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic last;      // held item is the last one of its message
		logic scan_done; // all filled entries compared
		logic out_free;  // result register can take a new result
	} sts_t;

	// one FNV-1a step
	function automatic logic [31:0] fnv_mix(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] x;
		begin
			x = h ^ {24'd0, b};
			return x * FNV_PRIME;
		end
	endfunction

endpackage

/* rtl/mdf_ram.sv */
// ----------------------------------------------------------------------------
// mdf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mdf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* rtl/mdf_dp.sv */
// ----------------------------------------------------------------------------
// mdf_dp
// Datapath: item and header holding registers, serial FNV-1a hash unit,
// ring cache with fill count and write pointer, scan compare and result
// register.
// ----------------------------------------------------------------------------
module mdf_dp #(
	parameter int CACHE_ENTRIES = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mdf_pkg::cmd_t     cmd,
	output mdf_pkg::sts_t     sts,
	input  logic [31:0]       sender_id,
	input  logic [63:0]       timestamp,
	input  logic [7:0]        msg_type,
	input  logic [7:0]        payload_length,
	input  logic [7:0]        payload_byte,
	input  logic              last_item,
	input  logic              record,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              is_duplicate,
	output logic [31:0]       hash
);

	import mdf_pkg::*;

	localparam int AW = $clog2(CACHE_ENTRIES);
	localparam int CW = $clog2(CACHE_ENTRIES + 1);

	logic [31:0]  sender_q;
	logic [63:0]  time_q;
	logic [7:0]   type_q;
	logic [7:0]   hdr_len_q;
	logic [7:0]   pay_q;
	logic         pay_nz_q;
	logic         last_q;
	logic         record_q;
	logic [31:0]  hash_q;
	logic [111:0] hdr_vec;
	logic [7:0]   sel_byte;
	logic         mix_now;

	logic [CW-1:0]      fill_q;
	logic [AW-1:0]      wp_q;
	logic [CW-1:0]      rd_cnt_q;
	logic               rd_vld_s1;
	logic               dup_q;
	logic               issue;
	logic               match;
	logic [ENTRY_W-1:0] rd_data;
	logic [ENTRY_W-1:0] wr_data;
	logic               wr_en;

	logic        out_vld_q;
	logic        dup_out_q;
	logic [31:0] hash_out_q;

	// hold item and header fields
	always_ff @(posedge clk) begin
		if (cmd.capture_item) begin
			pay_q    <= payload_byte;
			pay_nz_q <= (payload_length != 8'd0);
			last_q   <= last_item;
			record_q <= record;
		end
		if (cmd.capture_hdr) begin
			sender_q  <= sender_id;
			time_q    <= timestamp;
			type_q    <= msg_type;
			hdr_len_q <= payload_length;
		end
	end

	// select the byte to fold in, little-endian header order
	assign hdr_vec = {hdr_len_q, type_q, time_q, sender_q};

	always_comb begin
		if (cmd.byte_sel < HDR_BYTES) begin
			sel_byte = hdr_vec[{cmd.byte_sel, 3'b000} +: 8];
		end else begin
			sel_byte = pay_q;
		end
	end

	assign mix_now = cmd.mix_en && ((cmd.byte_sel != SEL_PAYLOAD) || pay_nz_q);

	// advance the hash one byte per cycle while mixing is enabled
	always_ff @(posedge clk) begin
		if (cmd.capture_hdr) begin
			hash_q <= FNV_BASIS;
		end else if (mix_now) begin
			hash_q <= fnv_mix(hash_q, sel_byte);
		end
	end

	// cache storage
	assign wr_en   = cmd.commit && record_q;
	assign wr_data = {sender_q, time_q, type_q, hash_q};
	assign issue   = cmd.scan_en && (rd_cnt_q < fill_q);

	mdf_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CACHE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wp_q),
		.wdata (wr_data),
		.re    (issue),
		.raddr (rd_cnt_q[AW-1:0]),
		.rdata (rd_data)
	);

	// compare one filled entry per cycle
	assign match = rd_vld_s1 && (rd_data == wr_data);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q  <= '0;
			rd_vld_s1 <= 1'b0;
			dup_q     <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (cmd.scan_clr) begin
				rd_cnt_q <= '0;
				dup_q    <= 1'b0;
			end else begin
				if (issue) begin
					rd_cnt_q <= rd_cnt_q + CW'(1);
				end
				if (match) begin
					dup_q <= 1'b1;
				end
			end
		end
	end

	// advance the ring pointer and fill count on a recorded message
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (wr_en) begin
			if (wp_q == AW'(CACHE_ENTRIES - 1)) begin
				wp_q <= '0;
			end else begin
				wp_q <= wp_q + AW'(1);
			end
			if (fill_q != CW'(CACHE_ENTRIES)) begin
				fill_q <= fill_q + CW'(1);
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.commit) begin
			out_vld_q <= 1'b1;
		end else if (!out_stall) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			dup_out_q  <= dup_q;
			hash_out_q <= hash_q;
		end
	end

	assign out_valid    = out_vld_q;
	assign is_duplicate = dup_out_q;
	assign hash         = hash_out_q;

	// status to controller
	assign sts.last      = last_q;
	assign sts.scan_done = cmd.scan_en && !issue && !rd_vld_s1;
	assign sts.out_free  = !out_vld_q || !out_stall;

endmodule

/* rtl/mdf_ctrl.sv */
// ----------------------------------------------------------------------------
// mdf_ctrl
// Controller: sequences item intake, header hashing, payload hashing, cache
// scan and result commit.
// ----------------------------------------------------------------------------
module mdf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  mdf_pkg::sts_t sts,
	output mdf_pkg::cmd_t cmd
);

	import mdf_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_HDR    = 5'b00010,
		ST_MIX    = 5'b00100,
		ST_SCAN   = 5'b01000,
		ST_RESULT = 5'b10000
	} state_t;

	state_t     state_q, state_d;
	logic [3:0] cnt_q, cnt_d;
	logic       in_msg_q, in_msg_d;

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		in_msg_d = in_msg_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.capture_item = 1'b1;
					if (!in_msg_q) begin
						cmd.capture_hdr = 1'b1;
						cnt_d           = '0;
						state_d         = ST_HDR;
					end else begin
						state_d = ST_MIX;
					end
				end
			end
			ST_HDR: begin
				cmd.mix_en   = 1'b1;
				cmd.byte_sel = cnt_q;
				if (cnt_q == HDR_BYTES - 4'd1) begin
					state_d = ST_MIX;
				end else begin
					cnt_d = cnt_q + 4'd1;
				end
			end
			ST_MIX: begin
				cmd.mix_en   = 1'b1;
				cmd.byte_sel = SEL_PAYLOAD;
				if (sts.last) begin
					cmd.scan_clr = 1'b1;
					state_d      = ST_SCAN;
				end else begin
					in_msg_d = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_SCAN: begin
				cmd.scan_en = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					in_msg_d   = 1'b0;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			in_msg_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			cnt_q    <= cnt_d;
			in_msg_q <= in_msg_d;
		end
	end

endmodule

/* rtl/message_duplicate_filter_top.sv */
// ----------------------------------------------------------------------------
// message_duplicate_filter_top
// Message duplicate filter: FNV-1a 32-bit fingerprint with a ring cache.
// ----------------------------------------------------------------------------
// Usage:
// A message enters on the input channel (in_valid/in_stall) as a run of
// transfers, one per payload byte, or one transfer for an empty payload.
// The first transfer carries sender_id, timestamp, msg_type and
// payload_length; last_item marks the final transfer, whose record bit
// asks for the fingerprint to be stored in the ring cache.
// One result per message leaves on the output channel (out_valid/out_stall):
// is_duplicate and the 32-bit hash.
// Operation: the 14 header bytes of the first transfer are hashed one per
// cycle by the shared FNV unit, then the payload byte; each later transfer
// folds in its payload byte. After the last transfer the cache memory is
// scanned one entry per cycle over the filled entries, then the result is
// loaded into the output register once that register is free.
// Reset empties the cache (fill count zero) and needs no clearing pass.
// A stalled result holds in its register; input transfers are still taken
// until the next result is ready, which then waits for the register.
// ----------------------------------------------------------------------------
module message_duplicate_filter_top #(
	parameter int CACHE_ENTRIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] sender_id,
	input  logic [63:0] timestamp,
	input  logic [7:0]  msg_type,
	input  logic [7:0]  payload_length,
	input  logic [7:0]  payload_byte,
	input  logic        last_item,
	input  logic        record,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        is_duplicate,
	output logic [31:0] hash
);

	import mdf_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequence control
	mdf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// hash, cache and result storage
	mdf_dp #(
		.CACHE_ENTRIES (CACHE_ENTRIES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.sender_id      (sender_id),
		.timestamp      (timestamp),
		.msg_type       (msg_type),
		.payload_length (payload_length),
		.payload_byte   (payload_byte),
		.last_item      (last_item),
		.record         (record),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.is_duplicate   (is_duplicate),
		.hash           (hash)
	);

`ifndef ASSERT_OFF
	// a committed result shows up on the output
	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid)
		else $error("committed result not presented");

	// never overwrite a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && out_valid) |-> !out_stall)
		else $error("pending result overwritten");

	// the block stalls input in the cycle after every input transfer
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken again without hashing");
`endif

endmodule

/* tb/sv/tb_message_duplicate_filter_top.sv */
// ----------------------------------------------------------------------------
// tb_message_duplicate_filter_top
// Self-checking bench for the message duplicate filter. A table of directed
// messages covers the header extremes, empty payloads, record on and off, and
// item counts that disagree with the length. Random messages follow: fresh
// ones, exact repeats and repeats with one bit changed. Both handshakes idle
// at random. Every result is checked against a fingerprint and ring cache
// predictor kept inside the bench.
// ----------------------------------------------------------------------------
module tb_message_duplicate_filter_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CACHE_DEPTH     = 64;
	localparam int ITEM_TARGET     = 900;
	localparam int HIST_DEPTH      = 16;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int SETTLE_CYCLES   = CACHE_DEPTH + 40;

	// what a directed row states about the duplicate flag of its result
	typedef enum logic [1:0] {HINT_NONE, HINT_UNIQUE, HINT_REPEAT} hint_t;

	typedef struct {
		logic [31:0] sender;
		logic [63:0] stamp;
		logic [7:0]  mtype;
		logic [7:0]  plen;
		logic [7:0]  pbyte;
		logic        last;
		logic        rec;
		hint_t       hint;
	} msg_item_t;

	typedef struct {
		logic        dup;
		logic [31:0] fp;
	} verdict_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] sender_id;
	logic [63:0] timestamp;
	logic [7:0]  msg_type;
	logic [7:0]  payload_length;
	logic [7:0]  payload_byte;
	logic        last_item;
	logic        record;
	logic        out_valid;
	logic        out_stall;
	logic        is_duplicate;
	logic [31:0] hash;

	message_duplicate_filter_top #(
		.CACHE_ENTRIES(CACHE_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sender_id(sender_id),
		.timestamp(timestamp),
		.msg_type(msg_type),
		.payload_length(payload_length),
		.payload_byte(payload_byte),
		.last_item(last_item),
		.record(record),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.is_duplicate(is_duplicate),
		.hash(hash)
	);

	// predictor state
	logic [31:0] run_hash     = mdf_pkg::FNV_BASIS;
	logic        mid_message  = 1'b0;
	logic [31:0] hold_sender  = '0;
	logic [63:0] hold_stamp   = '0;
	logic [7:0]  hold_type    = '0;
	logic [31:0] slot_sender [CACHE_DEPTH];
	logic [63:0] slot_stamp  [CACHE_DEPTH];
	logic [7:0]  slot_type   [CACHE_DEPTH];
	logic [31:0] slot_fp     [CACHE_DEPTH];
	bit          slot_valid  [CACHE_DEPTH];
	int          wr_ptr       = 0;

	verdict_t pending_verdicts[$];
	hint_t    verdict_hints[$];

	int  err_count     = 0;
	int  items_sent    = 0;
	int  items_taken   = 0;
	int  results_seen  = 0;
	int  repeats_seen  = 0;
	int  records_made  = 0;
	int  tx_idle_pct   = 19;
	int  rx_stall_pct  = 19;
	bit  hold_off_req  = 1'b0;
	int  quiet_cycles  = 0;

	msg_item_t pending_msg[$];
	msg_item_t recent_msgs [HIST_DEPTH][$];

	// directed messages, one row per transfer
	msg_item_t dir_rows [20] = '{
		// empty payload, all-zero header, recorded
		'{32'h0, 64'h0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1, HINT_UNIQUE},
		// same again, record off
		'{32'h0, 64'h0, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0, HINT_REPEAT},
		// all-ones header, length 255 but a single transfer
		'{32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1,
			HINT_UNIQUE},
		'{32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1,
			HINT_REPEAT},
		// same header, different payload byte: only the hash differs
		'{32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 8'hFF, 8'hFE, 1'b1, 1'b0,
			HINT_UNIQUE},
		// three bytes, record on early transfers only, junk header later
		'{32'hA5A5_5A5A, 64'h0123_4567_89AB_CDEF, 8'h03, 8'h03, 8'h11, 1'b0, 1'b1,
			HINT_NONE},
		'{32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 8'h03, 8'h22, 1'b0, 1'b1,
			HINT_NONE},
		'{32'h0, 64'h0, 8'h00, 8'h03, 8'h33, 1'b1, 1'b0, HINT_UNIQUE},
		// same message, now recorded
		'{32'hA5A5_5A5A, 64'h0123_4567_89AB_CDEF, 8'h03, 8'h03, 8'h11, 1'b0, 1'b0,
			HINT_NONE},
		'{32'h0, 64'h0, 8'h00, 8'h03, 8'h22, 1'b0, 1'b0, HINT_NONE},
		'{32'h0, 64'h0, 8'h00, 8'h03, 8'h33, 1'b1, 1'b1, HINT_UNIQUE},
		// and once more, record off
		'{32'hA5A5_5A5A, 64'h0123_4567_89AB_CDEF, 8'h03, 8'h03, 8'h11, 1'b0, 1'b0,
			HINT_NONE},
		'{32'h0, 64'h0, 8'h00, 8'h03, 8'h22, 1'b0, 1'b0, HINT_NONE},
		'{32'h0, 64'h0, 8'h00, 8'h03, 8'h33, 1'b1, 1'b0, HINT_REPEAT},
		// zero length on a middle transfer: its byte is skipped
		'{32'h1, 64'h1, 8'h80, 8'h02, 8'h40, 1'b0, 1'b0, HINT_NONE},
		'{32'h0, 64'h0, 8'h00, 8'h00, 8'h41, 1'b0, 1'b0, HINT_NONE},
		'{32'h0, 64'h0, 8'h00, 8'h02, 8'h42, 1'b1, 1'b1, HINT_UNIQUE},
		// more transfers than the length says
		'{32'h8000_0000, 64'h8000_0000_0000_0000, 8'h7F, 8'h01, 8'h5A, 1'b0, 1'b0,
			HINT_NONE},
		'{32'h0, 64'h0, 8'h00, 8'h01, 8'hA5, 1'b0, 1'b0, HINT_NONE},
		'{32'h0, 64'h0, 8'h00, 8'h01, 8'hC3, 1'b1, 1'b1, HINT_UNIQUE}
	};

	// one FNV-1a step
	function automatic logic [31:0] fold_byte(input logic [31:0] h, input logic [7:0] b);
		logic [31:0] x;
		x = h ^ {24'd0, b};
		return x * mdf_pkg::FNV_PRIME;
	endfunction

	// advance the predictor by one transfer; returns 1 when a result is due
	function automatic bit fingerprint_step(input logic [31:0] snd, input logic [63:0] stamp,
			input logic [7:0] mtype, input logic [7:0] plen, input logic [7:0] pbyte,
			input logic last, input logic rec, output logic dup, output logic [31:0] fp);
		logic [31:0] h;
		int          i;
		h   = run_hash;
		dup = 1'b0;
		fp  = '0;
		// header on the first transfer restarts the hash
		if (!mid_message) begin
			hold_sender = snd;
			hold_stamp  = stamp;
			hold_type   = mtype;
			h = mdf_pkg::FNV_BASIS;
			for (i = 0; i < 4; i++)
				h = fold_byte(h, snd[8*i +: 8]);
			for (i = 0; i < 8; i++)
				h = fold_byte(h, stamp[8*i +: 8]);
			h = fold_byte(h, mtype);
			h = fold_byte(h, plen);
		end
		if (plen != 0)
			h = fold_byte(h, pbyte);
		if (!last) begin
			run_hash    = h;
			mid_message = 1'b1;
			return 1'b0;
		end
		// scan the ring for a full match
		for (i = 0; i < CACHE_DEPTH; i++)
			if (slot_valid[i] && slot_sender[i] == hold_sender && slot_stamp[i] == hold_stamp
					&& slot_type[i] == hold_type && slot_fp[i] == h)
				dup = 1'b1;
		if (rec) begin
			slot_sender[wr_ptr] = hold_sender;
			slot_stamp[wr_ptr]  = hold_stamp;
			slot_type[wr_ptr]   = hold_type;
			slot_fp[wr_ptr]     = h;
			slot_valid[wr_ptr]  = 1'b1;
			wr_ptr = (wr_ptr + 1) % CACHE_DEPTH;
			records_made++;
		end
		run_hash    = mdf_pkg::FNV_BASIS;
		mid_message = 1'b0;
		fp = h;
		return 1'b1;
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// offer one transfer and hold it until it is taken
	task automatic put_item(input msg_item_t it);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		verdict_hints.push_back(it.hint);
		sender_id      <= it.sender;
		timestamp      <= it.stamp;
		msg_type       <= it.mtype;
		payload_length <= it.plen;
		payload_byte   <= it.pbyte;
		last_item      <= it.last;
		record         <= it.rec;
		in_valid       <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain_results();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending_verdicts.size() != 0);
	endtask

	// receiver: random stalls, or a long hold-off on request
	initial begin : receiver
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end else begin
				out_stall <= ($urandom_range(99) < rx_stall_pct);
			end
		end
	end

	// check results, then predict from the input transfer of this edge
	always @(posedge clk) begin : monitor
		verdict_t    want;
		hint_t       hint;
		logic        dup_p;
		logic [31:0] fp_p;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_verdicts.size() == 0) begin
					$error("unexpected result: is_duplicate=%0b hash=%08h", is_duplicate, hash);
					err_count++;
				end else begin
					want = pending_verdicts.pop_front();
					if (is_duplicate !== want.dup) begin
						$error("is_duplicate: expected %0b, got %0b", want.dup, is_duplicate);
						err_count++;
					end
					if (hash !== want.fp) begin
						$error("hash: expected %08h, got %08h", want.fp, hash);
						err_count++;
					end
					results_seen++;
					if (want.dup)
						repeats_seen++;
				end
			end
			if (in_valid && !in_stall) begin
				hint = verdict_hints.pop_front();
				if (fingerprint_step(sender_id, timestamp, msg_type, payload_length,
						payload_byte, last_item, record, dup_p, fp_p)) begin
					// a directed row may state the flag outright
					if (hint == HINT_REPEAT)
						dup_p = 1'b1;
					else if (hint == HINT_UNIQUE)
						dup_p = 1'b0;
					pending_verdicts.push_back('{dup_p, fp_p});
				end
				items_taken++;
			end
		end
	end

	// watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", quiet_cycles);
			$display("tb_message_duplicate_filter_top: done, errors");
			$finish;
		end
	end

	initial begin : stimulus
		msg_item_t   it;
		logic [31:0] hdr_sender;
		logic [63:0] hdr_stamp;
		logic [7:0]  hdr_type;
		logic [7:0]  hdr_len;
		int          msg_no;
		int          pick;
		int          n;
		int          j;
		int          hist_wr;
		int          hist_count;
		bit          well_formed;
		msg_no     = 0;
		hist_wr    = 0;
		hist_count = 0;
		foreach (slot_valid[i])
			slot_valid[i] = 1'b0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		sender_id      = '0;
		timestamp      = '0;
		msg_type       = '0;
		payload_length = '0;
		payload_byte   = '0;
		last_item      = 1'b0;
		record         = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_rows[r])
			put_item(dir_rows[r]);
		drain_results();

		// random messages
		while (items_sent < ITEM_TARGET) begin
			msg_no++;
			// a stretch with no idling on either side
			tx_idle_pct  = (msg_no >= 20 && msg_no < 40) ? 0 : 19;
			rx_stall_pct = (msg_no >= 20 && msg_no < 40) ? 0 : 19;
			// receiver holds off while the sender keeps offering
			if (msg_no == 50)
				hold_off_req = 1'b1;
			// sender waits for the pipeline to empty
			if (msg_no == 80 || msg_no == 120)
				drain_results();

			pick = $urandom_range(99);
			if (hist_count > 0 && pick < 30) begin
				// exact repeat with a fresh record choice
				pending_msg = recent_msgs[$urandom_range(hist_count - 1)];
				pending_msg[pending_msg.size() - 1].rec = ($urandom_range(3) != 0);
			end else if (hist_count > 0 && pick < 42) begin
				// repeat with one bit flipped
				pending_msg = recent_msgs[$urandom_range(hist_count - 1)];
				case ($urandom_range(3))
					0: begin
						n = $urandom_range(31);
						pending_msg[0].sender[n] = ~pending_msg[0].sender[n];
					end
					1: begin
						n = $urandom_range(63);
						pending_msg[0].stamp[n] = ~pending_msg[0].stamp[n];
					end
					2: begin
						n = $urandom_range(7);
						pending_msg[0].mtype[n] = ~pending_msg[0].mtype[n];
					end
					default: begin
						j = $urandom_range(pending_msg.size() - 1);
						n = $urandom_range(7);
						pending_msg[j].pbyte[n] = ~pending_msg[j].pbyte[n];
					end
				endcase
			end else begin
				// fresh message, mostly short and well formed
				hdr_sender = ($urandom_range(3) == 0) ? 32'($urandom_range(3)) : $urandom;
				hdr_stamp  = {$urandom, $urandom};
				hdr_type   = 8'($urandom_range(255));
				pick = $urandom_range(99);
				if (pick < 75)
					hdr_len = 8'($urandom_range(6));
				else if (pick < 99)
					hdr_len = 8'($urandom_range(24, 7));
				else
					hdr_len = 8'($urandom_range(255, 100));
				well_formed = ($urandom_range(99) < 85);
				if (well_formed)
					n = (hdr_len == 0) ? 1 : int'(hdr_len);
				else
					n = $urandom_range(int'(hdr_len) + 3, 1);
				pending_msg.delete();
				for (j = 0; j < n; j++) begin
					it.sender = (j == 0) ? hdr_sender : $urandom;
					it.stamp  = (j == 0) ? hdr_stamp : {$urandom, $urandom};
					it.mtype  = (j == 0) ? hdr_type : 8'($urandom_range(255));
					if (j == 0 || well_formed)
						it.plen = hdr_len;
					else
						it.plen = ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom_range(255));
					it.pbyte = 8'($urandom_range(255));
					it.last  = (j == n - 1);
					it.rec   = it.last ? ($urandom_range(3) != 0) : 1'($urandom_range(1));
					it.hint  = HINT_NONE;
					pending_msg.push_back(it);
				end
				recent_msgs[hist_wr] = pending_msg;
				hist_wr = (hist_wr + 1) % HIST_DEPTH;
				if (hist_count < HIST_DEPTH)
					hist_count++;
			end
			foreach (pending_msg[k])
				put_item(pending_msg[k]);
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_verdicts.size() != 0) begin
			$error("%0d results never arrived", pending_verdicts.size());
			err_count++;
		end
		$display("covered %0d transfers in %0d random messages, %0d results, %0d repeats",
			items_taken, msg_no, results_seen, repeats_seen);
		$display("%0d fingerprints stored, ring wrapped %0d times",
			records_made, records_made / CACHE_DEPTH);
		if (err_count == 0)
			$display("tb_message_duplicate_filter_top: done, clean");
		else
			$display("tb_message_duplicate_filter_top: done, errors");
		$finish;
	end

endmodule
